/* sv/cig_pkg.sv */
// Package for the chevron icon vertex generator: control word layout, sequencer
// opcodes, the microcode table and the fixed-point helpers of the datapath.
// Depends on nothing; the top level refers to it by scoped names.
package cig_pkg;

  localparam int unsigned PosW   = 27;   // pixel position in 1/1600 pixel units
  localparam int unsigned ProdW  = 52;   // position times Q2.22 scale
  localparam int unsigned ColW   = 15;
  localparam int unsigned StepW  = 6;    // 42 microcode steps
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW   = 24;

  localparam logic [CfgW-1:0] XScaleReset = 24'd4369;
  localparam logic [CfgW-1:0] YScaleReset = 24'd7767;

  localparam logic [CfgIdxW-1:0] CfgXScale = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgYScale = 2'd1;

  localparam logic [ColW-1:0] BorderGrey = 15'd655;
  localparam logic [ColW-1:0] OneQ14     = 15'd16384;

  // Rounding offset, half of 25 * 2^16, for the device coordinate division.
  localparam logic signed [ProdW-1:0] RoundHalf = 52'sd819200;
  // Bias that lifts the clamped quotient input above zero: 25 * 2^18.
  localparam logic signed [24:0] DivBias = 25'sd6553600;
  // ceil(2^29 / 25); exact floor division by 25 for all values below 2^24.
  localparam logic [24:0] RecipK = 25'd21474837;
  // 2^18 (undoes the bias) plus 4096 (one in Q4.12).
  localparam logic signed [21:0] NdcOffset = 22'sd266240;

  typedef enum logic [1:0] {
    UOP_NEXT,
    UOP_END_IF_SINGLE,
    UOP_END
  } uop_e;

  typedef struct packed {
    logic signed [7:0] cx;      // x offset in radii times 100
    logic signed [9:0] cy;      // y offset in radii times 100
    logic              border;  // vertex takes the grey border colour
    uop_e              op;
  } ucode_t;

  typedef struct packed {
    logic [ColW-1:0] red;
    logic [ColW-1:0] green;
    logic [ColW-1:0] blue;
    logic [ColW-1:0] alpha;
    logic            last;
  } attr_t;

  // Corner visited by each step of one arrow: outer corners 0..2, inner 3..5.
  function automatic logic [2:0] cig_point(input logic [4:0] k);
    logic [2:0] p;
    case (k)
      5'd0:  p = 3'd3;
      5'd1:  p = 3'd4;
      5'd2:  p = 3'd5;
      5'd3:  p = 3'd0;
      5'd4:  p = 3'd1;
      5'd5:  p = 3'd4;
      5'd6:  p = 3'd0;
      5'd7:  p = 3'd4;
      5'd8:  p = 3'd3;
      5'd9:  p = 3'd1;
      5'd10: p = 3'd2;
      5'd11: p = 3'd5;
      5'd12: p = 3'd1;
      5'd13: p = 3'd5;
      5'd14: p = 3'd4;
      5'd15: p = 3'd2;
      5'd16: p = 3'd0;
      5'd17: p = 3'd3;
      5'd18: p = 3'd2;
      5'd19: p = 3'd3;
      5'd20: p = 3'd5;
      default: p = 3'd0;
    endcase
    return p;
  endfunction

  // Microcode ROM: steps 0..20 draw the lower arrow, 21..41 the raised one.
  function automatic ucode_t cig_ucode(input logic [StepW-1:0] step);
    ucode_t            w;
    logic              upper;
    logic [4:0]        k;
    logic signed [9:0] cy_base;
    upper = (step >= 6'd21);
    k = upper ? 5'(step - 6'd21) : step[4:0];
    case (cig_point(k))
      3'd0: begin w.cx = 8'sd0;    cy_base = 10'sd0;    end
      3'd1: begin w.cx = -8'sd100; cy_base = -10'sd150; end
      3'd2: begin w.cx = 8'sd100;  cy_base = -10'sd150; end
      3'd3: begin w.cx = 8'sd0;    cy_base = -10'sd28;  end
      3'd4: begin w.cx = -8'sd72;  cy_base = -10'sd136; end
      3'd5: begin w.cx = 8'sd72;   cy_base = -10'sd136; end
      default: begin w.cx = 8'sd0; cy_base = 10'sd0;    end
    endcase
    w.cy = upper ? cy_base - 10'sd180 : cy_base;
    w.border = (k >= 5'd3);
    if (step == 6'd41) begin
      w.op = UOP_END;
    end else if (step == 6'd20) begin
      w.op = UOP_END_IF_SINGLE;
    end else begin
      w.op = UOP_NEXT;
    end
    return w;
  endfunction

  // floor((p + half) / 2^16), clamped to where the result already saturates,
  // then biased to a positive 24-bit value for the reciprocal multiply.
  function automatic logic [23:0] cig_fold(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] t;
    logic signed [35:0]      u;
    logic signed [22:0]      uc;
    logic signed [24:0]      vs;
    t = p + RoundHalf;
    u = t[ProdW-1:16];
    if (u > 36'sd4194303) begin
      uc = 23'sd4194303;
    end else if (u < -36'sd4194304) begin
      uc = -23'sd4194304;
    end else begin
      uc = u[22:0];
    end
    vs = 25'(uc) + DivBias;
    return vs[23:0];
  endfunction

  function automatic logic [15:0] cig_sat16(input logic signed [21:0] d);
    logic [15:0] r;
    if (d > 22'sd32767) begin
      r = 16'h7fff;
    end else if (d < -22'sd32768) begin
      r = 16'h8000;
    end else begin
      r = d[15:0];
    end
    return r;
  endfunction

  function automatic logic [ColW-1:0] cig_clamp_col(input logic signed [15:0] c);
    logic [ColW-1:0] r;
    if (c < 16'sd0) begin
      r = '0;
    end else if (c > 16'sd16384) begin
      r = OneQ14;
    end else begin
      r = c[ColW-1:0];
    end
    return r;
  endfunction

endpackage

/* sv/chevron_icon_vertex_generator_unit.sv */
// Top level of the chevron icon vertex generator: microcode sequencer, the
// two-lane device coordinate pipeline and the configuration registers.
// Depends on cig_pkg.
//
// A marker beat produces 21 vertex beats for a single arrow or 42 for two, one
// vertex per cycle while the output is taken: a step counter walks the
// microcode table and issues one vertex each cycle into a five-stage pipeline
// (offset multiply, scale multiply, round and clamp, reciprocal multiply,
// saturate). The next marker is accepted in the cycle after the last vertex
// of the current one is issued, while earlier vertices still drain. A marker
// with zero radius, opacity or count produces nothing and leaves the block
// ready. Scale registers are written through the configuration channel,
// which is always ready.
module chevron_icon_vertex_generator_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cig_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [cig_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [17:0]                tip_x_i,
  input  logic signed [17:0]                tip_y_i,
  input  logic [15:0]                       radius_i,
  input  logic [15:0]                       opacity_i,
  input  logic [7:0]                        item_count_i,
  input  logic signed [15:0]                color_r_i,
  input  logic signed [15:0]                color_g_i,
  input  logic signed [15:0]                color_b_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [15:0]                ndc_x_o,
  output logic signed [15:0]                ndc_y_o,
  output logic [cig_pkg::ColW-1:0]          out_red_o,
  output logic [cig_pkg::ColW-1:0]          out_green_o,
  output logic [cig_pkg::ColW-1:0]          out_blue_o,
  output logic [cig_pkg::ColW-1:0]          out_alpha_o,
  output logic                              last_vertex_o
);

  // Configuration registers.
  logic [cig_pkg::CfgW-1:0] x_scale_q, y_scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_scale_q <= cig_pkg::XScaleReset;
      y_scale_q <= cig_pkg::YScaleReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cig_pkg::CfgXScale: x_scale_q <= cfg_data_i;
        cig_pkg::CfgYScale: y_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Marker registers, loaded on an accepted beat.
  logic signed [24:0]        tx_q, ty_q;
  logic [15:0]               r_q;
  logic                      double_q;
  logic [cig_pkg::ColW-1:0]  fill_r_q, fill_g_q, fill_b_q, alpha_q;

  // Sequencer.
  logic                        busy_q, busy_d;
  logic [cig_pkg::StepW-1:0]   step_q, step_d;
  cig_pkg::ucode_t             uw;
  logic                        in_accept, live, en, issue, last_step;

  assign in_ready_o = !busy_q;
  assign in_accept  = in_valid_i && in_ready_o;
  assign live       = (radius_i != 16'd0) && (opacity_i != 16'd0) && (item_count_i != 8'd0);
  assign en         = !out_valid_o || out_ready_i;
  assign issue      = busy_q && en;
  assign uw         = cig_pkg::cig_ucode(step_q);

  always_comb begin
    case (uw.op)
      cig_pkg::UOP_NEXT:          last_step = 1'b0;
      cig_pkg::UOP_END_IF_SINGLE: last_step = !double_q;
      cig_pkg::UOP_END:           last_step = 1'b1;
      default:                    last_step = 1'b1;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    if (in_accept && live) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (issue) begin
      step_d = step_q + 6'd1;
      if (last_step) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tx_q     <= 25'(tip_x_i) * 25'sd100;
      ty_q     <= 25'(tip_y_i) * 25'sd100;
      r_q      <= radius_i;
      double_q <= (item_count_i > 8'd1);
      fill_r_q <= cig_pkg::cig_clamp_col(color_r_i);
      fill_g_q <= cig_pkg::cig_clamp_col(color_g_i);
      fill_b_q <= cig_pkg::cig_clamp_col(color_b_i);
      alpha_q  <= (opacity_i > 16'd16384) ? cig_pkg::OneQ14 : opacity_i[cig_pkg::ColW-1:0];
    end
  end

  // Pipeline. All stages move together whenever the output register can take
  // a beat; the valid bits follow the payload.
  logic                               s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic signed [cig_pkg::PosW-1:0]    px_s1_q, py_s1_q;
  logic signed [cig_pkg::ProdW-1:0]   px_s2_q, py_s2_q;
  logic [23:0]                        vx_s3_q, vy_s3_q;
  logic [48:0]                        wx_s4_q, wy_s4_q;
  cig_pkg::attr_t                     at_s1_q, at_s2_q, at_s3_q, at_s4_q, at_d;
  logic signed [24:0]                 cxr;
  logic signed [26:0]                 cyr;
  logic signed [21:0]                 dx, dy;
  logic                               out_valid_q;

  assign cxr = $signed({1'b0, r_q}) * uw.cx;
  assign cyr = $signed({1'b0, r_q}) * uw.cy;

  always_comb begin
    at_d.red   = uw.border ? cig_pkg::BorderGrey : fill_r_q;
    at_d.green = uw.border ? cig_pkg::BorderGrey : fill_g_q;
    at_d.blue  = uw.border ? cig_pkg::BorderGrey : fill_b_q;
    at_d.alpha = alpha_q;
    at_d.last  = last_step;
  end

  assign dx = $signed({2'b00, wx_s4_q[48:29]}) - cig_pkg::NdcOffset;
  assign dy = cig_pkg::NdcOffset - $signed({2'b00, wy_s4_q[48:29]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= issue;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_s1_q <= 27'(tx_q) + 27'(cxr);
      py_s1_q <= 27'(ty_q) + cyr;
      at_s1_q <= at_d;
      px_s2_q <= px_s1_q * $signed({1'b0, x_scale_q});
      py_s2_q <= py_s1_q * $signed({1'b0, y_scale_q});
      at_s2_q <= at_s1_q;
      vx_s3_q <= cig_pkg::cig_fold(px_s2_q);
      vy_s3_q <= cig_pkg::cig_fold(py_s2_q);
      at_s3_q <= at_s2_q;
      wx_s4_q <= 49'(vx_s3_q) * 49'(cig_pkg::RecipK);
      wy_s4_q <= 49'(vy_s3_q) * 49'(cig_pkg::RecipK);
      at_s4_q <= at_s3_q;
      ndc_x_o       <= cig_pkg::cig_sat16(dx);
      ndc_y_o       <= cig_pkg::cig_sat16(dy);
      out_red_o     <= at_s4_q.red;
      out_green_o   <= at_s4_q.green;
      out_blue_o    <= at_s4_q.blue;
      out_alpha_o   <= at_s4_q.alpha;
      last_vertex_o <= at_s4_q.last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* test/chevron_icon_vertex_generator_unit_checker.sv */
// Scoreboard for the chevron icon vertex generator: watches the scale, marker
// and vertex channels, predicts the vertex list of each marker and compares.
// Depends on cig_pkg for the register indexes and the scale reset values.
module chevron_icon_vertex_generator_unit_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [cig_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [cig_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic signed [17:0]          tip_x_i,
  input  logic signed [17:0]          tip_y_i,
  input  logic [15:0]                 radius_i,
  input  logic [15:0]                 opacity_i,
  input  logic [7:0]                  item_count_i,
  input  logic signed [15:0]          color_r_i,
  input  logic signed [15:0]          color_g_i,
  input  logic signed [15:0]          color_b_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic signed [15:0]          ndc_x_i,
  input  logic signed [15:0]          ndc_y_i,
  input  logic [14:0]                 out_red_i,
  input  logic [14:0]                 out_green_i,
  input  logic [14:0]                 out_blue_i,
  input  logic [14:0]                 out_alpha_i,
  input  logic                        last_vertex_i,
  output int unsigned                 pending_o,
  output int unsigned                 fail_count_o
);

  // Positions are held in 1/1600 pixel, so the shape factors become integers.
  localparam longint NdcDiv = 1638400;
  localparam longint NdcOne = 4096;
  localparam logic [14:0] BorderGrey = 15'd655;
  localparam logic [14:0] UnitQ14 = 15'd16384;

  typedef struct packed {
    logic signed [15:0] ndc_x;
    logic signed [15:0] ndc_y;
    logic [14:0]        red;
    logic [14:0]        green;
    logic [14:0]        blue;
    logic [14:0]        alpha;
    logic               last;
  } vertex_t;

  vertex_t     expected_vertices[$];
  logic [23:0] x_scale;
  logic [23:0] y_scale;
  int unsigned failures = 0;

  function automatic logic [15:0] device_coord(input longint pos, input logic [23:0] scale,
                                               input bit flip);
    longint prod, t, q, d;
    prod = pos * longint'(scale);
    t = prod + NdcDiv / 2;
    // Floor division, so the half step always rounds toward plus infinity.
    q = (t >= 0) ? t / NdcDiv : -((NdcDiv - 1 - t) / NdcDiv);
    d = flip ? NdcOne - q : q - NdcOne;
    if (d > 32767) begin
      d = 32767;
    end else if (d < -32768) begin
      d = -32768;
    end
    return d[15:0];
  endfunction

  function automatic logic [14:0] clamp_unit(input logic signed [15:0] c);
    if (c < 0) begin
      return '0;
    end
    if (c > 16384) begin
      return UnitQ14;
    end
    return c[14:0];
  endfunction

  function automatic vertex_t make_vertex(input longint px, input longint py,
                                          input logic [14:0] r, input logic [14:0] g,
                                          input logic [14:0] b, input logic [14:0] a);
    vertex_t v;
    v.ndc_x = device_coord(px, x_scale, 1'b0);
    v.ndc_y = device_coord(py, y_scale, 1'b1);
    v.red   = r;
    v.green = g;
    v.blue  = b;
    v.alpha = a;
    v.last  = 1'b0;
    return v;
  endfunction

  task automatic predict_chevrons();
    longint      tx, ty, r, tip, cy;
    longint      ox[3], oy[3], ix[3], iy[3];
    logic [14:0] fr, fg, fb, alpha;
    vertex_t     batch[$];
    vertex_t     tail;
    int          arrows, j;
    if (radius_i == 0 || opacity_i == 0 || item_count_i == 0) begin
      return;
    end
    tx = longint'(tip_x_i) * 100;
    ty = longint'(tip_y_i) * 100;
    r  = longint'(radius_i);
    fr = clamp_unit(color_r_i);
    fg = clamp_unit(color_g_i);
    fb = clamp_unit(color_b_i);
    alpha = (opacity_i > 16384) ? UnitQ14 : opacity_i[14:0];
    arrows = (item_count_i > 1) ? 2 : 1;
    for (int a = 0; a < arrows; a++) begin
      tip = ty - longint'(a) * r * 180;
      cy  = tip - r * 100;
      ox[0] = tx;           oy[0] = tip;
      ox[1] = tx - r * 100; oy[1] = tip - r * 150;
      ox[2] = tx + r * 100; oy[2] = tip - r * 150;
      ix[0] = tx;           iy[0] = cy + r * 72;
      ix[1] = tx - r * 72;  iy[1] = cy - r * 36;
      ix[2] = tx + r * 72;  iy[2] = cy - r * 36;
      for (int i = 0; i < 3; i++) begin
        batch.push_back(make_vertex(ix[i], iy[i], fr, fg, fb, alpha));
      end
      // Each edge of the border band is a quad split into two triangles.
      for (int i = 0; i < 3; i++) begin
        j = (i + 1) % 3;
        batch.push_back(make_vertex(ox[i], oy[i], BorderGrey, BorderGrey, BorderGrey, alpha));
        batch.push_back(make_vertex(ox[j], oy[j], BorderGrey, BorderGrey, BorderGrey, alpha));
        batch.push_back(make_vertex(ix[j], iy[j], BorderGrey, BorderGrey, BorderGrey, alpha));
        batch.push_back(make_vertex(ox[i], oy[i], BorderGrey, BorderGrey, BorderGrey, alpha));
        batch.push_back(make_vertex(ix[j], iy[j], BorderGrey, BorderGrey, BorderGrey, alpha));
        batch.push_back(make_vertex(ix[i], iy[i], BorderGrey, BorderGrey, BorderGrey, alpha));
      end
    end
    tail = batch.pop_back();
    tail.last = 1'b1;
    batch.push_back(tail);
    foreach (batch[k]) begin
      expected_vertices.push_back(batch[k]);
    end
  endtask

  function automatic void check_field(input string field, input integer want,
                                      input integer got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    vertex_t want;
    if (!rst_ni) begin
      x_scale = cig_pkg::XScaleReset;
      y_scale = cig_pkg::YScaleReset;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_vertices.size() == 0) begin
          $error("vertex beat with nothing expected: ndc_x %0d, ndc_y %0d", ndc_x_i, ndc_y_i);
          failures++;
        end else begin
          want = expected_vertices.pop_front();
          check_field("ndc_x", want.ndc_x, ndc_x_i);
          check_field("ndc_y", want.ndc_y, ndc_y_i);
          check_field("out_red", want.red, out_red_i);
          check_field("out_green", want.green, out_green_i);
          check_field("out_blue", want.blue, out_blue_i);
          check_field("out_alpha", want.alpha, out_alpha_i);
          check_field("last_vertex", want.last, last_vertex_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          cig_pkg::CfgXScale: x_scale = cfg_data_i;
          cig_pkg::CfgYScale: y_scale = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        predict_chevrons();
      end
    end
    pending_o    <= expected_vertices.size();
    fail_count_o <= failures;
  end

endmodule

/* test/chevron_icon_vertex_generator_unit_tb.sv */
// Top of the chevron icon vertex generator bench: clock, reset, scale writes,
// marker stimulus, output back-pressure, watchdog and the verdict.
// Depends on cig_pkg, the block and chevron_icon_vertex_generator_unit_checker.
module chevron_icon_vertex_generator_unit_tb;

  localparam int unsigned NumPhases     = 8;
  localparam int unsigned ItemsPerPhase = 40;
  localparam int unsigned SteadyPhase   = 2;
  localparam int unsigned PressurePhase = 5;
  localparam int unsigned RxHoldCycles  = 400;
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned WatchdogLimit = 4000;
  localparam logic [cig_pkg::CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [cig_pkg::CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef struct packed {
    logic signed [17:0] tip_x;
    logic signed [17:0] tip_y;
    logic [15:0]        radius;
    logic [15:0]        opacity;
    logic [7:0]         count;
    logic signed [15:0] col_r;
    logic signed [15:0] col_g;
    logic signed [15:0] col_b;
  } marker_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [cig_pkg::CfgIdxW-1:0] cfg_index;
  logic [cig_pkg::CfgW-1:0]    cfg_data;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [17:0]          tip_x;
  logic signed [17:0]          tip_y;
  logic [15:0]                 radius;
  logic [15:0]                 opacity;
  logic [7:0]                  item_count;
  logic signed [15:0]          color_r;
  logic signed [15:0]          color_g;
  logic signed [15:0]          color_b;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [15:0]          ndc_x;
  logic signed [15:0]          ndc_y;
  logic [14:0]                 out_red;
  logic [14:0]                 out_green;
  logic [14:0]                 out_blue;
  logic [14:0]                 out_alpha;
  logic                        last_vertex;
  int unsigned                 pending;
  int unsigned                 fail_count;
  int unsigned                 quiet_cycles = 0;
  bit                          rx_hold_req = 1'b0;
  bit                          rx_steady = 1'b0;

  chevron_icon_vertex_generator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .tip_x_i        (tip_x),
    .tip_y_i        (tip_y),
    .radius_i       (radius),
    .opacity_i      (opacity),
    .item_count_i   (item_count),
    .color_r_i      (color_r),
    .color_g_i      (color_g),
    .color_b_i      (color_b),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .ndc_x_o        (ndc_x),
    .ndc_y_o        (ndc_y),
    .out_red_o      (out_red),
    .out_green_o    (out_green),
    .out_blue_o     (out_blue),
    .out_alpha_o    (out_alpha),
    .last_vertex_o  (last_vertex)
  );

  chevron_icon_vertex_generator_unit_checker checker_u (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .tip_x_i        (tip_x),
    .tip_y_i        (tip_y),
    .radius_i       (radius),
    .opacity_i      (opacity),
    .item_count_i   (item_count),
    .color_r_i      (color_r),
    .color_g_i      (color_g),
    .color_b_i      (color_b),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .ndc_x_i        (ndc_x),
    .ndc_y_i        (ndc_y),
    .out_red_i      (out_red),
    .out_green_i    (out_green),
    .out_blue_i     (out_blue),
    .out_alpha_i    (out_alpha),
    .last_vertex_i  (last_vertex),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Any beat on any channel counts as progress.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("chevron_icon_vertex_generator_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Vertex receiver: mostly short stalls, a few long ones, and a long hold on request.
  initial begin : vertex_sink
    int unsigned pick, len;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        len = RxHoldCycles;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
        len = 1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 30);
        end else if (pick < 95) begin
          out_ready <= 1'b0;
          len = $urandom_range(1, 4);
        end else begin
          out_ready <= 1'b0;
          len = $urandom_range(10, 60);
        end
      end
      repeat (len) @(posedge clk_i);
    end
  end

  function automatic marker_t mk(input int tx, input int ty, input int r, input int op,
                                 input int cnt, input int cr, input int cg, input int cb);
    marker_t m;
    m.tip_x   = 18'(tx);
    m.tip_y   = 18'(ty);
    m.radius  = 16'(r);
    m.opacity = 16'(op);
    m.count   = 8'(cnt);
    m.col_r   = 16'(cr);
    m.col_g   = 16'(cg);
    m.col_b   = 16'(cb);
    return m;
  endfunction

  function automatic marker_t random_marker();
    marker_t m;
    int unsigned pick;
    m.tip_x = ($urandom_range(0, 99) < 70) ? 18'($urandom_range(0, 30720)) : 18'($urandom);
    m.tip_y = ($urandom_range(0, 99) < 70) ? 18'($urandom_range(0, 17280)) : 18'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      m.radius = 16'($urandom_range(1, 640));
    end else if (pick < 95) begin
      m.radius = 16'($urandom_range(1, 65535));
    end else begin
      m.radius = 16'hffff;
    end
    m.opacity = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(1, 65535))
                                            : 16'($urandom_range(1, 16384));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      m.count = 8'd1;
    end else if (pick < 90) begin
      m.count = 8'($urandom_range(2, 255));
    end else begin
      m.count = 8'($urandom);
    end
    m.col_r = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 16384)) : 16'($urandom);
    m.col_g = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 16384)) : 16'($urandom);
    m.col_b = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 16384)) : 16'($urandom);
    // A few markers are blanked by one of the three suppressing fields.
    if ($urandom_range(0, 99) < 8) begin
      case ($urandom_range(0, 2))
        0: m.radius = '0;
        1: m.opacity = '0;
        default: m.count = '0;
      endcase
    end
    return m;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      return 0;
    end
    if (pick < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  task automatic drain_vertices();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Valid stays high across back-to-back beats; it only drops for a gap or a drain.
  task automatic offer_marker(input marker_t m, input int unsigned gap, input bit drain_first);
    if (gap != 0 || drain_first) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (drain_first) begin
        drain_vertices();
      end
    end
    in_valid     <= 1'b1;
    tip_x        <= m.tip_x;
    tip_y        <= m.tip_y;
    radius       <= m.radius;
    opacity      <= m.opacity;
    item_count   <= m.count;
    color_r      <= m.col_r;
    color_g      <= m.col_g;
    color_b      <= m.col_b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [cig_pkg::CfgIdxW-1:0] idx,
                           input logic [cig_pkg::CfgW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task automatic load_scales(input int unsigned ph);
    logic [23:0] xs, ys;
    case (ph)
      1: begin xs = 24'd1; ys = 24'hffffff; end
      2: begin xs = 24'hffffff; ys = 24'd1; end
      3: begin xs = 24'd0; ys = 24'd0; end
      4: begin xs = cig_pkg::XScaleReset; ys = cig_pkg::YScaleReset; end
      default: begin
        xs = 24'($urandom_range(1, 24'hffffff));
        ys = 24'($urandom_range(1, 40000));
      end
    endcase
    write_reg(cig_pkg::CfgXScale, xs);
    write_reg(ph[0] ? CfgSpareA : CfgSpareB, 24'($urandom));
    write_reg(cig_pkg::CfgYScale, ys);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    offer_marker(mk(0, 0, 16, 16384, 1, 16384, 0, 8192), $urandom_range(0, 2), 1'b0);
    offer_marker(mk(131071, 131071, 65535, 65535, 255, 32767, -32768, 16385),
                 $urandom_range(0, 2), 1'b0);
    offer_marker(mk(-131072, -131072, 1, 1, 2, -1, 0, 16384), $urandom_range(0, 2), 1'b0);
    offer_marker(mk(5000, 3000, 0, 16384, 1, 100, 200, 300), $urandom_range(0, 2), 1'b0);
    offer_marker(mk(5000, 3000, 160, 0, 1, 100, 200, 300), $urandom_range(0, 2), 1'b0);
    offer_marker(mk(5000, 3000, 160, 16384, 0, 100, 200, 300), $urandom_range(0, 2), 1'b0);
    offer_marker(mk(131071, -131072, 65535, 16385, 1, 16383, 1, -16384),
                 $urandom_range(0, 2), 1'b0);
    offer_marker(mk(-131072, 131071, 320, 16383, 2, 20000, -5, 12345),
                 $urandom_range(0, 2), 1'b0);
    offer_marker(mk(15360, 8640, 160, 12000, 3, 4000, 9000, 13000), $urandom_range(0, 2), 1'b0);
    offer_marker(mk(30720, 17280, 65535, 1, 2, -32768, 32767, 0), $urandom_range(0, 2), 1'b0);
    offer_marker(mk(-1, -1, 1, 16384, 255, 16384, 16384, 16384), $urandom_range(0, 2), 1'b0);
    offer_marker(mk(16, 16, 8, 32768, 1, 1, -1, 16385), $urandom_range(0, 2), 1'b0);
  endtask

  initial begin : stimulus
    marker_t     m;
    int unsigned drawn;
    rst_ni       <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    tip_x        <= '0;
    tip_y        <= '0;
    radius       <= '0;
    opacity      <= '0;
    item_count   <= '0;
    color_r      <= '0;
    color_g      <= '0;
    color_b      <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      if (ph != 0) begin
        // Scales change only once the block has gone quiet.
        in_valid <= 1'b0;
        drain_vertices();
        repeat (SettleCycles) @(posedge clk_i);
        load_scales(ph);
      end
      rx_steady = (ph == SteadyPhase);
      if (ph == PressurePhase) begin
        rx_hold_req = 1'b1;
        for (int k = 0; k < 14; k++) begin
          m = random_marker();
          m.radius = 16'($urandom_range(1, 640));
          m.opacity = 16'($urandom_range(1, 65535));
          m.count = 8'($urandom_range(2, 255));
          offer_marker(m, 0, 1'b0);
        end
      end
      drawn = 0;
      while (drawn < ItemsPerPhase) begin
        m = random_marker();
        offer_marker(m, rx_steady ? 0 : pick_gap(), $urandom_range(0, 49) == 0);
        if (m.radius != 0 && m.opacity != 0 && m.count != 0) begin
          drawn++;
        end
      end
    end
    in_valid <= 1'b0;
    drain_vertices();
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("chevron_icon_vertex_generator_unit: match");
    end else begin
      $display("chevron_icon_vertex_generator_unit: mismatch");
    end
    $finish;
  end

endmodule
